// File: src/utf8_decode_cell_width_core_assert.svh
// Assertion macros for the UTF-8 decoder block.
`ifndef UTF8_DECODE_CELL_WIDTH_CORE_ASSERT_SVH
`define UTF8_DECODE_CELL_WIDTH_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define U8DCW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("u8dcw: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define U8DCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("u8dcw: next-cycle check failed");

`endif

// File: src/u8dcw_pkg.sv
`default_nettype none

package u8dcw_pkg;

	localparam int WIDTH_BITS = 16;
	localparam int CP_W       = 21;
	localparam int WT_W       = 16;

	localparam logic [CP_W-1:0] REPL_CP = 21'h00fffd;

	// Sequence lengths held in the pending-length register
	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_TWO  = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR = 3'd4;

	// Results planned for one input byte: rep_cnt replacements, then an optional tail
	typedef struct packed {
		logic [1:0]      rep_cnt;
		logic            tail;
		logic [CP_W-1:0] tail_cp;
		logic            tail_repl;
		logic            fin;
	} plan_t;

endpackage

`default_nettype wire

// File: src/utf8_decode_cell_width_core.sv
// Path: plan stage, then output register; results leave when downstream is ready.
// Throughput: one byte per cycle while downstream is ready and no byte yields more
// than one result. A byte with k results (k up to 4) holds the input until the plan
// stage hands over its last one; silent bytes never enter the plan stage.
// Reset: arst_n clears the pending sequence, the running width and all valid flags.
`default_nettype none

module utf8_decode_cell_width_core
	import u8dcw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] in_byte
	input  wire logic        s_axis_tlast,  // final_byte
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [39:0] m_axis_tdata,  // [20:0] char_val, [21] replaced,
	                                        // [22] cells, [38:23] width_total, [39] zero
	output      logic        m_axis_tlast,  // run_last
	output      logic [0:0]  m_axis_tuser   // [0] string_done
);

`include "utf8_decode_cell_width_core_assert.svh"

	// Pending sequence state
	logic [2:0]      exp_q;
	logic [1:0]      held_q;
	logic [CP_W-1:0] pv_q;
	logic [2:0]      exp_d;
	logic [1:0]      held_d;
	logic [CP_W-1:0] pv_d;

	// Running width
	logic [WIDTH_BITS-1:0] wcnt_q;
	logic [WIDTH_BITS-1:0] wnext;
	logic [31:0]           wnext_ext;

	// Plan stage
	plan_t plan_d;
	plan_t plan_s1;
	logic  vld_s1;

	// Output register
	logic            out_vld_q;
	logic [CP_W-1:0] out_cp_q;
	logic            out_repl_q;
	logic            out_cells_q;
	logic [WT_W-1:0] out_wt_q;
	logic            out_last_q;
	logic            out_done_q;

	logic            acc;
	logic            adv;
	logic            emit;
	logic            emit_rep;
	logic [CP_W-1:0] e_cp;
	logic            e_repl;
	logic            e_last;
	logic            e_cells;

	// Decode of the incoming byte against the pending sequence
	logic [7:0]      b;
	logic            fin;
	logic            pend;
	logic            cont;
	logic            fresh;
	logic [1:0]      held_inc;
	logic [CP_W-1:0] pv_shift;

	always_comb begin
		b        = s_axis_tdata;
		fin      = s_axis_tlast;
		pend     = (exp_q != LEN_NONE);
		cont     = (b[7:6] == 2'b10);
		held_inc = held_q + 2'd1;
		pv_shift = {pv_q[CP_W-7:0], b[5:0]};
		fresh    = 1'b1;
		exp_d    = exp_q;
		held_d   = held_q;
		pv_d     = pv_q;
		plan_d.rep_cnt   = 2'd0;
		plan_d.tail      = 1'b0;
		plan_d.tail_cp   = REPL_CP;
		plan_d.tail_repl = 1'b1;
		plan_d.fin       = fin;

		if (pend) begin
			if (cont) begin
				// Gather six more bits; emit once the sequence is complete
				fresh  = 1'b0;
				pv_d   = pv_shift;
				held_d = held_inc;
				if (({1'b0, held_inc} + 3'd1) >= exp_q) begin
					plan_d.tail      = 1'b1;
					plan_d.tail_cp   = pv_shift;
					plan_d.tail_repl = 1'b0;
					exp_d  = LEN_NONE;
					held_d = 2'd0;
					pv_d   = '0;
				end else if (fin) begin
					// Lead plus held bytes, this one included, all become U+FFFD
					plan_d.rep_cnt = held_inc;
					plan_d.tail    = 1'b1;
				end
			end else begin
				// Wrong byte: replace lead and held bytes, then decode it afresh
				plan_d.rep_cnt = held_q + 2'd1;
			end
		end

		if (fresh) begin
			exp_d  = LEN_NONE;
			held_d = 2'd0;
			pv_d   = '0;
			priority if (!b[7]) begin
				plan_d.tail      = 1'b1;
				plan_d.tail_cp   = CP_W'(b);
				plan_d.tail_repl = 1'b0;
			end else if (b[7:5] == 3'b110) begin
				exp_d = LEN_TWO;
				pv_d  = CP_W'(b[4:0]);
			end else if (b[7:4] == 4'b1110) begin
				exp_d = LEN_THREE;
				pv_d  = CP_W'(b[3:0]);
			end else if (b[7:3] == 5'b11110) begin
				exp_d = LEN_FOUR;
				pv_d  = CP_W'(b[2:0]);
			end else begin
				// Stray continuation byte or invalid lead
				plan_d.tail = 1'b1;
			end
			// A lead on the final byte stands alone
			if (fin && (exp_d != LEN_NONE)) begin
				plan_d.tail = 1'b1;
			end
		end

		// Drop anything pending at the end of the string
		if (fin) begin
			exp_d  = LEN_NONE;
			held_d = 2'd0;
			pv_d   = '0;
		end
	end

	// Next result out of the plan stage: replacements first, then the tail
	always_comb begin
		emit_rep = (plan_s1.rep_cnt != 2'd0);
		e_cp     = emit_rep ? REPL_CP : plan_s1.tail_cp;
		e_repl   = emit_rep ? 1'b1 : plan_s1.tail_repl;
		e_last   = emit_rep ? ((plan_s1.rep_cnt == 2'd1) && !plan_s1.tail) : 1'b1;
		e_cells  = (e_cp != '0);
		wnext    = (e_cells && (wcnt_q != '1)) ? wcnt_q + 1'b1 : wcnt_q;
		wnext_ext = 32'(wnext);
	end

	// Advance the output register when it is empty or being taken
	assign adv  = !out_vld_q || m_axis_tready;
	assign emit = adv && vld_s1;
	// Take a new byte once the plan stage is empty or hands over its last result
	assign s_axis_tready = !vld_s1 || (emit && e_last);
	assign acc  = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q  <= LEN_NONE;
			held_q <= 2'd0;
			pv_q   <= '0;
		end else if (acc) begin
			exp_q  <= exp_d;
			held_q <= held_d;
			pv_q   <= pv_d;
		end
	end

	// Plan stage; a byte with no results never enters it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			plan_s1 <= '0;
		end else if (acc) begin
			vld_s1  <= (plan_d.rep_cnt != 2'd0) || plan_d.tail;
			plan_s1 <= plan_d;
		end else if (emit) begin
			if (e_last) begin
				vld_s1 <= 1'b0;
			end else begin
				plan_s1.rep_cnt <= plan_s1.rep_cnt - 2'd1;
			end
		end
	end

	// Running width: cleared after the last result of a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q <= '0;
		end else if (emit) begin
			wcnt_q <= (e_last && plan_s1.fin) ? '0 : wnext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_cp_q    <= e_cp;
			out_repl_q  <= e_repl;
			out_cells_q <= e_cells;
			out_wt_q    <= wnext_ext[WT_W-1:0];
			out_last_q  <= e_last;
			out_done_q  <= e_last && plan_s1.fin;
		end
	end

	assign m_axis_tvalid   = out_vld_q;
	assign m_axis_tdata    = {1'b0, out_wt_q, out_cells_q, out_repl_q, out_cp_q};
	assign m_axis_tlast    = out_last_q;
	assign m_axis_tuser[0] = out_done_q;

	`U8DCW_ASSERT_NOW(a_repl_cp, clk, arst_n, out_vld_q && out_repl_q, out_cp_q == REPL_CP)
	`U8DCW_ASSERT_NOW(a_cells, clk, arst_n, out_vld_q, out_cells_q == (out_cp_q != '0))
	`U8DCW_ASSERT_NOW(a_done_last, clk, arst_n, out_vld_q && out_done_q, out_last_q)
	`U8DCW_ASSERT_NOW(a_plan_busy, clk, arst_n, vld_s1, |plan_s1.rep_cnt || plan_s1.tail)
	`U8DCW_ASSERT_NOW(a_held, clk, arst_n, exp_q != LEN_NONE, ({1'b0, held_q} + 3'd2) <= exp_q)
	`U8DCW_ASSERT_NOW(a_width_clear, clk, arst_n, out_vld_q && out_done_q, wcnt_q == '0)

endmodule

`default_nettype wire

// File: bench/utf8_decode_cell_width_core_test.sv
`timescale 1ns / 100ps

module utf8_decode_cell_width_core_test;
	import u8dcw_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_BYTES = 320;
	localparam int QUIET_TAIL   = 60;
	localparam int SETTLE       = 8;

	// Byte classes: top bits of a UTF-8 byte
	localparam logic [7:0] TOP2_MASK = 8'hc0;
	localparam logic [7:0] CONT_TAG  = 8'h80;

	// One decoded result as it leaves the block
	typedef struct packed {
		logic [CP_W-1:0] char_val;
		logic            replaced;
		logic            cells;
		logic [WT_W-1:0] width_total;
		logic            run_last;
		logic            string_done;
	} glyph_t;

	// Directed stimulus row; known rows carry a typed character value and flag
	typedef struct packed {
		logic [7:0]      in_byte;
		logic            final_byte;
		logic            known;
		logic [CP_W-1:0] cp;
		logic            repl;
	} stim_row_t;

	localparam int NUM_ROWS = 25;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b1;
	logic [39:0] m_axis_tdata;  // [20:0] char_val, [21] replaced, [22] cells,
	                            // [38:23] width_total, [39] zero
	logic        m_axis_tlast;  // run_last
	logic [0:0]  m_axis_tuser;  // [0] string_done

	utf8_decode_cell_width_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	always #10 clk = ~clk;

	// Decoder state mirrored by the testbench
	logic [2:0]            pend_len = LEN_NONE;
	logic [1:0]            held_conts = '0;
	logic [CP_W-1:0]       gathered = '0;
	logic [WIDTH_BITS-1:0] running_cells = '0;

	glyph_t due_glyphs[$];

	int  err_count = 0;
	int  cycles = 0;
	int  bytes_sent = 0;
	int  strings_sent = 0;
	int  glyphs_seen = 0;
	int  repl_seen = 0;
	bit  quiet = 1'b0;
	int  stall_left = 0;

	// Build one result and advance the running width (saturating)
	function automatic glyph_t make_glyph(input logic [CP_W-1:0] cp, input logic repl);
		glyph_t g;
		g.char_val    = cp;
		g.replaced    = repl;
		g.cells       = (cp != '0);
		if (g.cells && running_cells != '1)
			running_cells = running_cells + 1'b1;
		g.width_total = WT_W'(running_cells);
		g.run_last    = 1'b0;
		g.string_done = 1'b0;
		return g;
	endfunction

	function automatic void drop_pending();
		pend_len   = LEN_NONE;
		held_conts = '0;
		gathered   = '0;
	endfunction

	// Decode one byte and queue the results it causes
	function automatic void decode_utf8_byte(input logic [7:0] b, input logic fin);
		glyph_t step_out[$];
		glyph_t g;
		logic   fresh;
		fresh = 1'b1;
		if (pend_len != LEN_NONE) begin
			if ((b & TOP2_MASK) == CONT_TAG) begin
				fresh      = 1'b0;
				gathered   = {gathered[CP_W-7:0], b[5:0]};
				held_conts = held_conts + 1'b1;
				if (int'(held_conts) + 1 >= int'(pend_len)) begin
					step_out.push_back(make_glyph(gathered, 1'b0));
					drop_pending();
				end else if (fin) begin
					// string ends inside the sequence: lead and every held byte
					for (int k = 0; k <= int'(held_conts); k++)
						step_out.push_back(make_glyph(REPL_CP, 1'b1));
					drop_pending();
				end
			end else begin
				// wrong byte inside a sequence: flush, then decode it afresh
				for (int k = 0; k <= int'(held_conts); k++)
					step_out.push_back(make_glyph(REPL_CP, 1'b1));
				drop_pending();
			end
		end
		if (fresh) begin
			if (!b[7]) begin
				step_out.push_back(make_glyph(CP_W'(b), 1'b0));
			end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
				if (b[7:5] == 3'b110) begin
					pend_len = LEN_TWO;
					gathered = CP_W'(b[4:0]);
				end else if (b[7:4] == 4'b1110) begin
					pend_len = LEN_THREE;
					gathered = CP_W'(b[3:0]);
				end else begin
					pend_len = LEN_FOUR;
					gathered = CP_W'(b[2:0]);
				end
				held_conts = '0;
				if (fin) begin
					// lead on the last byte
					step_out.push_back(make_glyph(REPL_CP, 1'b1));
					drop_pending();
				end
			end else begin
				// stray continuation or invalid lead
				step_out.push_back(make_glyph(REPL_CP, 1'b1));
			end
		end
		if (step_out.size() > 0) begin
			g = step_out.pop_back();
			g.run_last    = 1'b1;
			g.string_done = fin;
			step_out.push_back(g);
		end
		if (fin) begin
			drop_pending();
			running_cells = '0;
		end
		foreach (step_out[i])
			due_glyphs.push_back(step_out[i]);
	endfunction

	// Drive one byte at the current edge and hold it until the transfer
	task automatic put_byte(input logic [7:0] b, input logic fin);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= fin;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		decode_utf8_byte(b, fin);
		bytes_sent++;
		if (fin)
			strings_sent++;
	endtask

	function automatic logic [7:0] lead_byte(input int len);
		case (len)
			2:       return {3'b110, 5'($urandom_range(0, 31))};
			3:       return {4'b1110, 4'($urandom_range(0, 15))};
			default: return {5'b11110, 3'($urandom_range(0, 7))};
		endcase
	endfunction

	function automatic logic [7:0] cont_byte();
		return {2'b10, 6'($urandom_range(0, 63))};
	endfunction

	// Mostly well-formed characters, with some noise and cut-off sequences
	task automatic send_string();
		logic [7:0] seq[$];
		int nchar, kind, len, keep;
		nchar = $urandom_range(1, 8);
		for (int c = 0; c < nchar; c++) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				seq.push_back(8'($urandom_range(0, 127)));
			end else if (kind < 75) begin
				len = (kind < 45) ? 2 : (kind < 60) ? 3 : 4;
				seq.push_back(lead_byte(len));
				for (int k = 1; k < len; k++)
					seq.push_back(cont_byte());
			end else if (kind < 82) begin
				seq.push_back(cont_byte());
			end else if (kind < 87) begin
				seq.push_back(8'($urandom_range(8'hf8, 8'hff)));
			end else begin
				len  = $urandom_range(2, 4);
				keep = $urandom_range(0, len - 2);
				seq.push_back(lead_byte(len));
				for (int k = 0; k < keep; k++)
					seq.push_back(cont_byte());
			end
		end
		// now and then cut the string off inside a sequence
		if ($urandom_range(0, 99) < 15) begin
			len  = $urandom_range(2, 4);
			keep = $urandom_range(0, len - 2);
			seq.push_back(lead_byte(len));
			for (int k = 0; k < keep; k++)
				seq.push_back(cont_byte());
		end
		foreach (seq[i])
			put_byte(seq[i], i == seq.size() - 1);
	endtask

	// Hold the input low until every queued result has drained
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (due_glyphs.size() != 0)
			@(posedge clk);
	endtask

	// Downstream side: ready, with random stall bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left    <= $urandom_range(0, 5);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Compare each result transfer with the oldest queued result
	always @(posedge clk) begin
		glyph_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			glyphs_seen++;
			if (m_axis_tdata[21])
				repl_seen++;
			if (due_glyphs.size() == 0) begin
				$error("unexpected result: char_val %h", m_axis_tdata[20:0]);
				err_count++;
			end else begin
				want = due_glyphs.pop_front();
				if (m_axis_tdata[20:0] !== want.char_val) begin
					$error("char_val: expected %h, got %h", want.char_val,
						m_axis_tdata[20:0]);
					err_count++;
				end
				if (m_axis_tdata[21] !== want.replaced) begin
					$error("replaced: expected %b, got %b", want.replaced, m_axis_tdata[21]);
					err_count++;
				end
				if (m_axis_tdata[22] !== want.cells) begin
					$error("cells: expected %b, got %b", want.cells, m_axis_tdata[22]);
					err_count++;
				end
				if (m_axis_tdata[38:23] !== want.width_total) begin
					$error("width_total: expected %0d, got %0d", want.width_total,
						m_axis_tdata[38:23]);
					err_count++;
				end
				if (m_axis_tdata[39] !== 1'b0) begin
					$error("pad: expected 0, got %b", m_axis_tdata[39]);
					err_count++;
				end
				if (m_axis_tlast !== want.run_last) begin
					$error("run_last: expected %b, got %b", want.run_last, m_axis_tlast);
					err_count++;
				end
				if (m_axis_tuser[0] !== want.string_done) begin
					$error("string_done: expected %b, got %b", want.string_done,
						m_axis_tuser[0]);
					err_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("utf8_decode_cell_width_core_test: done, errors");
			$finish;
		end
	end

	// Directed rows: ASCII extremes, each sequence length, every error path
	stim_row_t dir_rows[NUM_ROWS] = '{
		'{8'h00, 1'b0, 1'b1, 21'h000000, 1'b0},  // NUL, zero cells
		'{8'h7f, 1'b0, 1'b1, 21'h00007f, 1'b0},  // top of ASCII
		'{8'hc3, 1'b0, 1'b0, 21'h0, 1'b0},       // two-byte form
		'{8'ha9, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'he2, 1'b0, 1'b0, 21'h0, 1'b0},       // three-byte form
		'{8'h82, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'hac, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'hf0, 1'b0, 1'b0, 21'h0, 1'b0},       // four-byte form
		'{8'h9f, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'h98, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'h80, 1'b0, 1'b1, REPL_CP, 1'b1},     // stray continuation
		'{8'hff, 1'b0, 1'b1, REPL_CP, 1'b1},     // invalid lead, top
		'{8'hf8, 1'b0, 1'b1, REPL_CP, 1'b1},     // invalid lead, bottom
		'{8'he2, 1'b0, 1'b0, 21'h0, 1'b0},       // wrong byte mid-sequence
		'{8'h82, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'h41, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'hf0, 1'b0, 1'b0, 21'h0, 1'b0},       // string ends mid-sequence
		'{8'h90, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'h80, 1'b1, 1'b0, 21'h0, 1'b0},
		'{8'hc2, 1'b1, 1'b1, REPL_CP, 1'b1},     // lead on the last byte
		'{8'hf7, 1'b0, 1'b0, 21'h0, 1'b0},       // largest four-byte value
		'{8'hbf, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'hbf, 1'b0, 1'b0, 21'h0, 1'b0},
		'{8'hbf, 1'b1, 1'b0, 21'h0, 1'b0}
	};

	initial begin
		glyph_t g;
		int random_start;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			put_byte(dir_rows[i].in_byte, dir_rows[i].final_byte);
			// typed rows: swap in the hand-written character value and flag
			if (dir_rows[i].known) begin
				g = due_glyphs.pop_back();
				g.char_val = dir_rows[i].cp;
				g.replaced = dir_rows[i].repl;
				due_glyphs.push_back(g);
			end
		end
		drain_results();

		random_start = bytes_sent;
		while (bytes_sent - random_start < RANDOM_BYTES) begin
			if (bytes_sent - random_start >= RANDOM_BYTES - QUIET_TAIL)
				quiet <= 1'b1;
			send_string();
			// one mid-run pause until the output side is empty
			if (strings_sent == 12)
				drain_results();
		end

		drain_results();
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d bytes in %0d strings: all sequence lengths, truncation,",
			bytes_sent, strings_sent);
		$display("stray and invalid bytes; %0d results checked, %0d replacements",
			glyphs_seen, repl_seen);
		if (err_count == 0 && due_glyphs.size() == 0) begin
			$display("utf8_decode_cell_width_core_test: done, clean");
		end else begin
			$display("utf8_decode_cell_width_core_test: done, errors");
		end
		$finish;
	end

endmodule

// File: utf8_decode_cell_width_core.f
+incdir+src
src/u8dcw_pkg.sv
src/utf8_decode_cell_width_core.sv
bench/utf8_decode_cell_width_core_test.sv
